[hw/rtl/ibus_pkg.sv]
// Shared types and constants of the i-BUS servo frame receiver.
package ibus_pkg;

  localparam int unsigned FRAME_BYTES = 32;

  localparam logic [7:0]  HEADER_SYNC    = 8'h20;
  localparam logic [7:0]  HEADER_CMD     = 8'h40;
  localparam logic [5:0]  CSUM_LAST_BYTE = 6'd29;
  localparam logic [5:0]  POS_HUNT       = 6'd0;
  localparam logic [5:0]  POS_BODY_FIRST = 6'd2;
  localparam logic [5:0]  POS_FIRST_CH_HI = 6'd3;
  localparam logic [5:0]  POS_CSUM_HI    = 6'(FRAME_BYTES - 1);
  localparam logic [15:0] CSUM_INIT      = 16'hFFFF;
  localparam logic [15:0] CSUM_AFTER_HDR = CSUM_INIT - 16'(HEADER_SYNC) - 16'(HEADER_CMD);

  typedef enum logic [1:0] {
    STATUS_DATA     = 2'd0,
    STATUS_CSUM_ERR = 2'd1,
    STATUS_LOST     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_EMIT
  } state_e;

endpackage

[hw/rtl/ibus_frame_receiver.sv]
// Top level of the i-BUS servo frame receiver: header hunt, checksum and channel report.
//
// Usage: the slave stream carries one beat per received UART byte (tdata) or per
// inter-byte gap timeout (tuser set). The block hunts for the header bytes 0x20 0x40,
// collects the 28 body bytes, keeps the running checksum and stores the little-endian
// channel words. After the trailing checksum word it reports either one beat per
// configured channel (tlast on the final one) or a single checksum-error beat. A count
// of zero reports one channel and counts above MAX_CHANNELS report MAX_CHANNELS.
// A gap while a frame is open gives one signal-lost beat and the block resyncs.
// Each input beat is accepted, then makes one pass through the shared 16-bit
// subtractor that updates the checksum; no new beat is taken before that pass. The
// final frame byte is followed by a compare on the same subtractor, then one reported
// channel beat per cycle while the master side does not stall. Results go through a
// single output register; a stalled master holds that register and the sequencer
// waits before loading the next beat, nothing is dropped. s_axis_tready is high only
// while the sequencer is idle.
// The configuration channel is always ready; write it only while the block is idle.
// Reset returns to header hunting with a reported channel count of 4; the channel
// store is not cleared since every word is written in a frame before it is reported.
module ibus_frame_receiver
  import ibus_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel: number of reported channels
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] gap_event
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] channel_index, [19:4] channel_value, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast
);

  localparam int unsigned IdxW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [3:0]  MaxCnt  = 4'(MAX_CHANNELS);
  localparam logic [3:0]  MaxLast = 4'(MAX_CHANNELS - 1);

  state_e      state_q, state_d;
  logic [3:0]  ch_count_q, ch_count_d;
  logic [5:0]  pos_q, pos_d;
  logic        seen_first_q, seen_first_d;
  logic [15:0] csum_q, csum_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  byte_q, byte_d;
  logic        gap_q, gap_d;
  status_e     kind_q, kind_d;
  logic [3:0]  emit_cnt_q, emit_cnt_d;
  logic [3:0]  last_idx_q, last_idx_d;

  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [3:0]  out_index_q, out_index_d;
  logic [15:0] out_value_q, out_value_d;
  logic        out_last_q, out_last_d;

  logic [15:0] store_q [MAX_CHANNELS];
  logic        store_we;
  logic [IdxW-1:0] store_widx;
  logic [15:0] store_wdata;
  logic [15:0] store_rdata_q;

  logic [15:0] alu_b;
  logic [15:0] alu_diff;
  logic [5:0]  pos_rel;
  logic [4:0]  word_idx;
  logic        in_accept;
  logic        slot_free;
  logic        emit_last;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign slot_free = !out_valid_q || m_axis_tready;

  // The one shared subtractor: byte removal from the checksum in EXEC, and the
  // compare against the received checksum word in CHECK (zero difference is a match).
  assign alu_b    = (state_q == ST_CHECK) ? {byte_q, low_q} : {8'd0, byte_q};
  assign alu_diff = csum_q - alu_b;

  // Odd body positions carry the high byte of a channel word.
  assign pos_rel  = pos_q - POS_FIRST_CH_HI;
  assign word_idx = pos_rel[5:1];

  assign emit_last   = (kind_q != STATUS_DATA) || (emit_cnt_q == last_idx_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (gap_q) begin
          state_d = (pos_q != POS_HUNT) ? ST_EMIT : ST_IDLE;
        end else if (pos_q == POS_CSUM_HI) begin
          state_d = ST_CHECK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (slot_free && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    ch_count_d   = ch_count_q;
    pos_d        = pos_q;
    seen_first_d = seen_first_q;
    csum_d       = csum_q;
    low_d        = low_q;
    byte_d       = byte_q;
    gap_d        = gap_q;
    kind_d       = kind_q;
    emit_cnt_d   = emit_cnt_q;
    last_idx_d   = last_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    store_we     = 1'b0;
    store_widx   = word_idx[IdxW-1:0];
    store_wdata  = {byte_q, low_q};

    if (cfg_valid_i) ch_count_d = cfg_data_i;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          byte_d = s_axis_tdata;
          gap_d  = s_axis_tuser[0];
        end
      end
      ST_EXEC: begin
        if (gap_q) begin
          pos_d        = POS_HUNT;
          seen_first_d = 1'b0;
          csum_d       = CSUM_INIT;
          low_d        = 8'd0;
          kind_d       = STATUS_LOST;
          emit_cnt_d   = 4'd0;
        end else if (pos_q == POS_HUNT) begin
          if (seen_first_q && byte_q == HEADER_CMD) begin
            csum_d       = CSUM_AFTER_HDR;
            pos_d        = POS_BODY_FIRST;
            seen_first_d = 1'b0;
          end else begin
            seen_first_d = (byte_q == HEADER_SYNC);
          end
        end else if (pos_q <= CSUM_LAST_BYTE) begin
          csum_d = alu_diff;
          if (!pos_q[0]) begin
            low_d = byte_q;
          end else if (5'(word_idx) < 5'(MaxCnt)) begin
            store_we = 1'b1;
          end
          pos_d = pos_q + 6'd1;
        end else if (pos_q != POS_CSUM_HI) begin
          low_d = byte_q;
          pos_d = pos_q + 6'd1;
        end
      end
      ST_CHECK: begin
        kind_d     = (alu_diff == 16'd0) ? STATUS_DATA : STATUS_CSUM_ERR;
        emit_cnt_d = 4'd0;
        // Out-of-range counts: zero reports one channel, large values saturate.
        if (ch_count_q == 4'd0) begin
          last_idx_d = 4'd0;
        end else if (ch_count_q > MaxCnt) begin
          last_idx_d = MaxLast;
        end else begin
          last_idx_d = ch_count_q - 4'd1;
        end
        pos_d        = POS_HUNT;
        seen_first_d = 1'b0;
        csum_d       = CSUM_INIT;
        low_d        = 8'd0;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = kind_q;
          out_last_d   = emit_last;
          if (kind_q == STATUS_DATA) begin
            out_index_d = emit_cnt_q;
            out_value_d = store_rdata_q;
          end else begin
            out_index_d = 4'd0;
            out_value_d = 16'd0;
          end
          emit_cnt_d = emit_cnt_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ch_count_q   <= 4'd4;
      pos_q        <= POS_HUNT;
      seen_first_q <= 1'b0;
      csum_q       <= CSUM_INIT;
      low_q        <= 8'd0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ch_count_q   <= ch_count_d;
      pos_q        <= pos_d;
      seen_first_q <= seen_first_d;
      csum_q       <= csum_d;
      low_q        <= low_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q       <= byte_d;
    gap_q        <= gap_d;
    kind_q       <= kind_d;
    emit_cnt_q   <= emit_cnt_d;
    last_idx_q   <= last_idx_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
    out_value_q  <= out_value_d;
    out_last_q   <= out_last_d;
  end

  // The read address follows the next emit count, so the word for the coming
  // channel beat is already registered when the sequencer loads it.
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[store_widx] <= store_wdata;
    store_rdata_q <= store_q[emit_cnt_d[IdxW-1:0]];
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_value_q, out_index_q};
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the i-BUS frame receiver: directed rows, then random frame traffic.
`timescale 1ns / 100ps

module testbench;
  import ibus_pkg::*;

  // Frame layout as seen on the wire.
  localparam logic [7:0] SYNC_BYTE      = 8'h20;
  localparam logic [7:0] CMD_BYTE       = 8'h40;
  localparam logic [5:0] HUNTING        = 6'd0;
  localparam logic [5:0] FIRST_BODY_POS = 6'd2;
  localparam logic [5:0] FIRST_HI_POS   = 6'd3;
  localparam logic [5:0] LAST_SUM_POS   = 6'd29;
  localparam logic [5:0] TRAILER_HI_POS = 6'd31;
  localparam int         CHANNELS_MAX   = 14;
  localparam int         BODY_BYTES     = 28;
  localparam int         FULL_FRAME     = 30;  // post-header bytes of a whole frame

  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AFTER   = 8;
  localparam int IDLE_WAIT    = 8;
  localparam int END_TAIL     = 20;
  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 8;
  localparam int PLAN_ROWS    = 21;

  typedef struct packed {
    status_e     status;
    logic [3:0]  index;
    logic [15:0] value;
    logic        is_last;
  } report_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_GAP,
    ROW_FRAME
  } row_kind_e;

  typedef enum logic [1:0] {
    CHECK_PREDICT,  // results come from the frame model
    CHECK_NONE,     // the row must cause no result at all
    CHECK_FAULT     // the row must cause one error beat of the given status
  } verdict_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  fill;   // byte value, or first body byte of a frame
    logic [7:0]  step;   // increment between body bytes
    logic [15:0] flip;   // XOR mask applied to the trailing checksum word
    logic [4:0]  cut;    // post-header bytes sent before a gap; FULL_FRAME sends all
    verdict_e    verdict;
    status_e     fault;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Model state of the receiver.
  logic [3:0]  report_channels;
  logic [5:0]  frame_pos;
  logic        sync_seen;
  logic [15:0] sum_left;
  logic [7:0]  low_hold;
  logic [15:0] channel_words [CHANNELS_MAX];

  report_t     pending_reports [$];
  row_t        plan [PLAN_ROWS];
  int          fail_count = 0;
  int          bytes_fed = 0;
  int          reports_seen = 0;
  int          cycle_count = 0;
  int unsigned feed_burst = 0;
  int unsigned drain_burst = 0;

  ibus_frame_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void enter_hunt();
    frame_pos = HUNTING;
    sync_seen = 1'b0;
    sum_left  = 16'hFFFF;
    low_hold  = 8'd0;
  endfunction

  // Advances the frame model by one accepted beat and, when trusted, queues the reports it causes.
  function automatic void predict_channel_reports(input logic gap, input logic [7:0] rx,
                                                  input bit trusted);
    logic [15:0] trailer;
    logic [15:0] computed;
    logic [5:0]  word_offset;
    int          count;
    if (gap) begin
      if (frame_pos != HUNTING && trusted) begin
        pending_reports.push_back('{STATUS_LOST, 4'd0, 16'd0, 1'b1});
      end
      enter_hunt();
    end else if (frame_pos == HUNTING) begin
      if (sync_seen && rx == CMD_BYTE) begin
        sum_left  = 16'hFFFF - 16'(SYNC_BYTE) - 16'(CMD_BYTE);
        frame_pos = FIRST_BODY_POS;
        sync_seen = 1'b0;
      end else begin
        sync_seen = (rx == SYNC_BYTE);
      end
    end else if (frame_pos <= LAST_SUM_POS) begin
      sum_left = sum_left - 16'(rx);
      if (!frame_pos[0]) begin
        low_hold = rx;
      end else begin
        word_offset = (frame_pos - FIRST_HI_POS) >> 1;
        channel_words[word_offset[3:0]] = {rx, low_hold};
      end
      frame_pos = frame_pos + 6'd1;
    end else if (frame_pos < TRAILER_HI_POS) begin
      low_hold  = rx;
      frame_pos = frame_pos + 6'd1;
    end else begin
      trailer  = {rx, low_hold};
      computed = sum_left;
      enter_hunt();
      if (!trusted) begin
        return;
      end
      if (trailer != computed) begin
        pending_reports.push_back('{STATUS_CSUM_ERR, 4'd0, 16'd0, 1'b1});
      end else begin
        // Out-of-range settings are clamped to one and to the full channel set.
        count = (report_channels == 4'd0) ? 1 :
                (report_channels > CHANNELS_MAX) ? CHANNELS_MAX : int'(report_channels);
        for (int k = 0; k < count; k++) begin
          pending_reports.push_back('{STATUS_DATA, 4'(k), channel_words[k], k == count - 1});
        end
      end
    end
  endfunction

  // Draws the wait before the next beat; now and then a run of back-to-back beats follows.
  function automatic int unsigned next_pause(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic feed_beat(input logic gap, input logic [7:0] rx, input bit trusted);
    int unsigned pause;
    pause = next_pause(feed_burst);
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= gap;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_channel_reports(gap, rx, trusted);
    if (!gap) begin
      bytes_fed++;
    end
  endtask

  // Sends header, body and trailer; a short cut ends the frame early with a gap beat.
  task automatic feed_frame(input logic [7:0] body [BODY_BYTES], input logic [15:0] flip,
                            input int cut, input bit trusted);
    logic [15:0] trailer;
    logic [7:0]  tail_bytes [FULL_FRAME];
    trailer = 16'hFFFF - 16'(SYNC_BYTE) - 16'(CMD_BYTE);
    for (int i = 0; i < BODY_BYTES; i++) begin
      trailer = trailer - 16'(body[i]);
      tail_bytes[i] = body[i];
    end
    trailer = trailer ^ flip;
    tail_bytes[BODY_BYTES]     = trailer[7:0];
    tail_bytes[BODY_BYTES + 1] = trailer[15:8];
    feed_beat(1'b0, SYNC_BYTE, trusted);
    feed_beat(1'b0, CMD_BYTE, trusted);
    for (int i = 0; i < cut; i++) begin
      feed_beat(1'b0, tail_bytes[i], trusted);
    end
    if (cut < FULL_FRAME) begin
      feed_beat(1'b1, 8'($urandom_range(0, 255)), trusted);
    end
  endtask

  // Lets every queued report drain, then gives the block time to finish a silent beat.
  task automatic settle(input int tail);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_channel_total(input logic [3:0] count);
    settle(IDLE_WAIT);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    report_channels = count;
  endtask

  task automatic random_sequence();
    logic [7:0] body [BODY_BYTES];
    int         pick;
    int         shape;
    pick  = $urandom_range(0, 9);
    shape = $urandom_range(0, 7);
    for (int i = 0; i < BODY_BYTES; i++) begin
      body[i] = (shape == 0) ? 8'h00 : (shape == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    end
    if (pick <= 5) begin
      if ($urandom_range(0, 3) == 0) begin
        feed_beat(1'b0, SYNC_BYTE, 1'b1);
      end
      feed_frame(body, 16'd0, FULL_FRAME, 1'b1);
    end else if (pick == 6) begin
      feed_frame(body, 16'($urandom_range(1, 16'hFFFF)), FULL_FRAME, 1'b1);
    end else if (pick == 7) begin
      feed_frame(body, 16'd0, $urandom_range(0, FULL_FRAME - 1), 1'b1);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       feed_beat(1'b0, SYNC_BYTE, 1'b1);
          1:       feed_beat(1'b0, CMD_BYTE, 1'b1);
          default: feed_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        endcase
      end
    end else begin
      feed_beat(1'b1, 8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic check_report();
    report_t want;
    reports_seen++;
    if (pending_reports.size() == 0) begin
      $error("result beat with nothing pending: tuser %0d tdata %h tlast %0d",
             m_axis_tuser, m_axis_tdata, m_axis_tlast);
      fail_count++;
      return;
    end
    want = pending_reports.pop_front();
    if (m_axis_tuser !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
      fail_count++;
    end
    if (m_axis_tdata[3:0] !== want.index) begin
      $error("channel_index: expected %0d, actual %0d", want.index, m_axis_tdata[3:0]);
      fail_count++;
    end
    if (m_axis_tdata[19:4] !== want.value) begin
      $error("channel_value: expected %h, actual %h", want.value, m_axis_tdata[19:4]);
      fail_count++;
    end
    if (m_axis_tlast !== want.is_last) begin
      $error("last: expected %0d, actual %0d", want.is_last, m_axis_tlast);
      fail_count++;
    end
  endtask

  // Result side: random stalls, plus one long hold-off that backs the block up into its input.
  initial begin
    int unsigned pause;
    bit          held_off;
    held_off = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      pause = next_pause(drain_burst);
      if (!held_off && reports_seen >= HOLD_AFTER) begin
        pause    = LONG_HOLD;
        held_off = 1'b1;
      end
      if (pause > 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_report();
    end
  end

  initial begin
    logic [7:0] body [BODY_BYTES];
    logic [3:0] phase_counts [PHASES];
    bit         trusted;
    int         phase_end;

    plan = '{
      // gap while hunting right after reset
      '{ROW_GAP,   8'hA5, 8'h00, 16'h0000, 5'd0,           CHECK_NONE,    STATUS_DATA},
      '{ROW_BYTE,  8'h40, 8'h00, 16'h0000, 5'd0,           CHECK_NONE,    STATUS_DATA},
      // repeated sync bytes ahead of the header, then a gap right after it
      '{ROW_BYTE,  8'h20, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_BYTE,  8'h20, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_FRAME, 8'h00, 8'h00, 16'h0000, 5'd0,           CHECK_FAULT,   STATUS_LOST},
      // header bytes that are not adjacent must not open a frame
      '{ROW_BYTE,  8'h20, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_BYTE,  8'h00, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_BYTE,  8'h40, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_GAP,   8'h00, 8'h00, 16'h0000, 5'd0,           CHECK_NONE,    STATUS_DATA},
      // a gap between the header bytes clears the sync
      '{ROW_BYTE,  8'h20, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_GAP,   8'hFF, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_BYTE,  8'h40, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_GAP,   8'h00, 8'h00, 16'h0000, 5'd0,           CHECK_NONE,    STATUS_DATA},
      '{ROW_BYTE,  8'hFF, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      '{ROW_BYTE,  8'h00, 8'h00, 16'h0000, 5'd0,           CHECK_PREDICT, STATUS_DATA},
      // good frames with all-zero and all-ones bodies, then one with a flipped checksum bit
      '{ROW_FRAME, 8'h00, 8'h00, 16'h0000, 5'(FULL_FRAME), CHECK_PREDICT, STATUS_DATA},
      '{ROW_FRAME, 8'hFF, 8'h00, 16'h0000, 5'(FULL_FRAME), CHECK_PREDICT, STATUS_DATA},
      '{ROW_FRAME, 8'h11, 8'h13, 16'h0001, 5'(FULL_FRAME), CHECK_FAULT,   STATUS_CSUM_ERR},
      // gap in place of the last trailer byte
      '{ROW_FRAME, 8'h5A, 8'h01, 16'h0000, 5'd29,          CHECK_FAULT,   STATUS_LOST},
      // rejected frame whose body carries header bytes, then a good one
      '{ROW_FRAME, 8'h20, 8'h20, 16'hFFFF, 5'(FULL_FRAME), CHECK_FAULT,   STATUS_CSUM_ERR},
      '{ROW_FRAME, 8'h80, 8'h01, 16'h0000, 5'(FULL_FRAME), CHECK_PREDICT, STATUS_DATA}
    };

    report_channels = 4'd4;
    enter_hunt();
    for (int i = 0; i < CHANNELS_MAX; i++) begin
      channel_words[i] = 16'd0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run with the reset channel count.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      trusted = (plan[r].verdict == CHECK_PREDICT);
      case (plan[r].kind)
        ROW_BYTE: feed_beat(1'b0, plan[r].fill, trusted);
        ROW_GAP:  feed_beat(1'b1, plan[r].fill, trusted);
        default: begin
          for (int i = 0; i < BODY_BYTES; i++) begin
            body[i] = 8'(plan[r].fill + 8'(i) * plan[r].step);
          end
          feed_frame(body, plan[r].flip, int'(plan[r].cut), trusted);
        end
      endcase
      if (plan[r].verdict == CHECK_FAULT) begin
        pending_reports.push_back('{plan[r].fault, 4'd0, 16'd0, 1'b1});
      end
    end

    // Random traffic under several channel counts, both clamp cases and both ends of the range.
    phase_counts = '{4'd0, 4'd15, 4'd1, 4'd14, 4'd0, 4'd0};
    phase_counts[4] = 4'($urandom_range(2, 13));
    phase_counts[5] = 4'($urandom_range(0, 15));
    for (int p = 0; p < PHASES; p++) begin
      write_channel_total(phase_counts[p]);
      phase_end = bytes_fed + PHASE_BYTES;
      while (bytes_fed < phase_end) begin
        random_sequence();
      end
    end

    settle(END_TAIL);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[ibus_frame_receiver.f]
hw/rtl/ibus_pkg.sv
hw/rtl/ibus_frame_receiver.sv
dv/testbench.sv
